@@ sv/ctw_pkg.sv @@
package ctw_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int COPY_COUNT    = CELL_COUNT - SCREEN_WIDTH;

  // Field widths.
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int IDX_W    = 11;
  localparam int CELL_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int COLOR_W  = 4;
  localparam int ATTR_W   = 2 * COLOR_W;
  localparam int ADDR_W   = $clog2(CELL_COUNT);

  // Command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NONE      = 8'h00;

  // Color register reset values.
  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT_CHAR   = 2'd0,
    OP_CLEAR      = 2'd1,
    OP_SET_CURSOR = 2'd2,
    OP_READ_CELL  = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_FG_COLOR = 1'b0,
    REG_BG_COLOR = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_CLEAR,
    CMD_SET_CURSOR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  chr;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [ADDR_W-1:0]  addr;
    logic               addr_ok;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_FLUSH,
    ST_CLEAR,
    ST_DONE
  } back_state_t;

endpackage

@@ sv/ctw_ram.sv @@
module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ctw_fifo.sv @@
module ctw_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ctw_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output ctw_pkg::cmd_t out_cmd
);
  import ctw_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_write;
  logic              do_read;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_ptr];
  assign do_write  = in_valid && in_ready;
  assign do_read   = out_valid && out_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_write) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_read) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_write && !do_read) begin
        count <= count + 1'b1;
      end else if (do_read && !do_write) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/ctw_front.sv @@
module ctw_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [ctw_pkg::OPCODE_W-1:0] opcode,
  input  logic [ctw_pkg::CHAR_W-1:0]   char_code,
  input  logic [ctw_pkg::COL_W-1:0]    column,
  input  logic [ctw_pkg::ROW_W-1:0]    row,
  input  logic [ctw_pkg::IDX_W-1:0]    cell_index,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output ctw_pkg::cmd_t                cmd
);
  import ctw_pkg::*;

  cmd_t stage_cmd;
  cmd_t cls;
  logic stage_valid;
  logic stage_valid_next;
  logic accept;

  assign full      = stage_valid && !cmd_ready;
  assign accept    = push && !full;
  assign cmd_valid = stage_valid;
  assign cmd       = stage_cmd;

  // Classify the request and clamp its operands.
  always_comb begin
    cls         = '0;
    cls.kind    = CMD_PRINT;
    cls.chr     = char_code;
    cls.col     = column;
    cls.row     = row;
    cls.addr    = ADDR_W'(cell_index);
    cls.addr_ok = 1'b0;
    case (opcode_t'(opcode))
      OP_PUT_CHAR: begin
        if (char_code == CH_NEWLINE) begin
          cls.kind = CMD_NEWLINE;
        end else if (char_code == CH_BACKSPACE) begin
          cls.kind = CMD_BACKSPACE;
        end else begin
          cls.kind = CMD_PRINT;
        end
      end
      OP_CLEAR: begin
        cls.kind = CMD_CLEAR;
      end
      OP_SET_CURSOR: begin
        cls.kind = CMD_SET_CURSOR;
        if (column >= COL_W'(SCREEN_WIDTH)) begin
          cls.col = COL_W'(SCREEN_WIDTH - 1);
        end
        if (row >= ROW_W'(SCREEN_HEIGHT)) begin
          cls.row = ROW_W'(SCREEN_HEIGHT - 1);
        end
      end
      OP_READ_CELL: begin
        cls.kind    = CMD_READ;
        cls.addr_ok = (cell_index < IDX_W'(CELL_COUNT));
      end
      default: begin
        cls.kind = CMD_PRINT;
      end
    endcase
  end

  // The stage holds its command until the queue takes it.
  always_comb begin
    stage_valid_next = accept || (stage_valid && !cmd_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd <= cls;
    end
  end

endmodule

@@ sv/ctw_back.sv @@
module ctw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ctw_pkg::ATTR_W-1:0]  attr,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  ctw_pkg::cmd_t               cmd,
  input  logic                        pop,
  output logic                        empty,
  output logic [ctw_pkg::IDX_W-1:0]   cursor_pos,
  output logic [ctw_pkg::CELL_W-1:0]  cell_data,
  output logic [ctw_pkg::COUNT_W-1:0] text_length
);
  import ctw_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  logic [COL_W-1:0]     cur_col;
  logic [COL_W-1:0]     cur_col_next;
  logic [ROW_W-1:0]     cur_row;
  logic [ROW_W-1:0]     cur_row_next;
  logic [COUNT_W-1:0]   char_count;
  logic [COUNT_W-1:0]   char_count_next;
  logic [ADDR_W-1:0]    sweep;
  logic [ADDR_W-1:0]    sweep_next;
  logic                 wr_valid;
  logic                 wr_valid_next;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    wr_addr_next;
  logic                 wr_copy;
  logic                 wr_copy_next;
  logic                 read_hit;
  logic                 read_hit_next;
  logic                 out_valid;
  logic                 out_load;
  logic [IDX_W-1:0]     out_pos;
  logic [CELL_W-1:0]    out_data;
  logic [COUNT_W-1:0]   out_len;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [CELL_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [CELL_W-1:0]    ram_rdata;

  logic [ADDR_W-1:0]    cur_addr;
  logic [CELL_W-1:0]    blank_cell;
  logic [CELL_W-1:0]    fill_cell;
  logic                 at_last_col;
  logic                 at_last_row;

  assign cur_addr    = ADDR_W'(cur_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cur_col);
  assign blank_cell  = {attr, CH_BLANK};
  assign fill_cell   = {attr, CH_NONE};
  assign at_last_col = (cur_col == COL_W'(SCREEN_WIDTH - 1));
  assign at_last_row = (cur_row == ROW_W'(SCREEN_HEIGHT - 1));
  assign cmd_ready   = (state == ST_IDLE);
  assign out_load    = (state == ST_DONE) && (!out_valid || pop);

  assign empty       = !out_valid;
  assign cursor_pos  = out_pos;
  assign cell_data   = out_data;
  assign text_length = out_len;

  ctw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Command sequencer: one step for ordinary commands, a sweep for scroll and clear.
  always_comb begin
    state_next      = state;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    char_count_next = char_count;
    sweep_next      = sweep;
    wr_valid_next   = wr_valid;
    wr_addr_next    = wr_addr;
    wr_copy_next    = wr_copy;
    read_hit_next   = read_hit;
    ram_we          = 1'b0;
    ram_waddr       = cur_addr;
    ram_wdata       = blank_cell;
    ram_re          = 1'b0;
    ram_raddr       = cmd.addr;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next    = ST_DONE;
          read_hit_next = 1'b0;
          sweep_next    = '0;
          wr_valid_next = 1'b0;
          case (cmd.kind)
            CMD_PRINT, CMD_NEWLINE: begin
              if (cmd.kind == CMD_PRINT) begin
                ram_we    = 1'b1;
                ram_wdata = {attr, cmd.chr};
                if (char_count != '1) begin
                  char_count_next = char_count + 1'b1;
                end
              end
              if (cmd.kind == CMD_PRINT && !at_last_col) begin
                cur_col_next = cur_col + 1'b1;
              end else begin
                // Line break: move to the next row, scrolling at the bottom.
                cur_col_next = '0;
                if (at_last_row) begin
                  state_next = ST_SCROLL;
                end else begin
                  cur_row_next = cur_row + 1'b1;
                end
              end
            end
            CMD_BACKSPACE: begin
              if (cur_col != '0) begin
                cur_col_next = cur_col - 1'b1;
                ram_we       = 1'b1;
                ram_waddr    = cur_addr - 1'b1;
                ram_wdata    = blank_cell;
                if (char_count != '0) begin
                  char_count_next = char_count - 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              state_next = ST_CLEAR;
            end
            CMD_SET_CURSOR: begin
              cur_col_next = cmd.col;
              cur_row_next = cmd.row;
            end
            CMD_READ: begin
              ram_re        = 1'b1;
              ram_raddr     = cmd.addr;
              read_hit_next = cmd.addr_ok;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // Read one row below, write the previous read back one row up.
        ram_re        = (sweep < ADDR_W'(COPY_COUNT));
        ram_raddr     = sweep + ADDR_W'(SCREEN_WIDTH);
        ram_we        = wr_valid;
        ram_waddr     = wr_addr;
        ram_wdata     = wr_copy ? ram_rdata : fill_cell;
        wr_valid_next = 1'b1;
        wr_addr_next  = sweep;
        wr_copy_next  = (sweep < ADDR_W'(COPY_COUNT));
        sweep_next    = sweep + 1'b1;
        if (sweep == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        ram_we        = wr_valid;
        ram_waddr     = wr_addr;
        ram_wdata     = wr_copy ? ram_rdata : fill_cell;
        wr_valid_next = 1'b0;
        state_next    = ST_DONE;
      end
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = sweep;
        ram_wdata  = blank_cell;
        sweep_next = sweep + 1'b1;
        if (sweep == ADDR_W'(CELL_COUNT - 1)) begin
          cur_col_next = '0;
          cur_row_next = '0;
          state_next   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          read_hit_next = 1'b0;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_col    <= '0;
      cur_row    <= '0;
      char_count <= '0;
      wr_valid   <= 1'b0;
      read_hit   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      char_count <= char_count_next;
      wr_valid   <= wr_valid_next;
      read_hit   <= read_hit_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sweep and result payload registers.
  always_ff @(posedge clk) begin
    sweep   <= sweep_next;
    wr_addr <= wr_addr_next;
    wr_copy <= wr_copy_next;
    if (out_load) begin
      out_pos  <= IDX_W'(cur_addr);
      out_data <= read_hit ? ram_rdata : '0;
      out_len  <= char_count;
    end
  end

endmodule

@@ sv/text_console_cell_writer_core.sv @@
// Text console cell writer. Requests enter through a queue-style port (push/full) and
// each produces exactly one result on a queue-style port (empty/pop) that reports the
// cursor position, the cell read (zero unless an in-range read cell request) and the
// character count. A front stage classifies requests into a two-entry command queue;
// the back sequencer executes them one at a time against a single-port-write,
// registered-read screen memory. Put char, newline, backspace, set cursor and read
// cell execute in the sequencer, which then loads the result register once the
// previous result is taken. A scroll sweeps the screen one cell per cycle through the
// memory's read and write ports, copying each row up one row and filling the last row
// with empty cells; clear screen writes one blank cell per cycle. Colors are written
// through the cfg port, which is always ready, and apply to cells the sequencer writes
// afterwards. Cells never written since reset read back as undefined.
module text_console_cell_writer_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [ctw_pkg::OPCODE_W-1:0] opcode,
  input  logic [ctw_pkg::CHAR_W-1:0]   char_code,
  input  logic [ctw_pkg::COL_W-1:0]    column,
  input  logic [ctw_pkg::ROW_W-1:0]    row,
  input  logic [ctw_pkg::IDX_W-1:0]    cell_index,
  output logic                         empty,
  input  logic                         pop,
  output logic [ctw_pkg::IDX_W-1:0]    cursor_pos,
  output logic [ctw_pkg::CELL_W-1:0]   cell_data,
  output logic [ctw_pkg::COUNT_W-1:0]  text_length,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [ctw_pkg::COLOR_W-1:0]  cfg_data
);
  import ctw_pkg::*;

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic               front_valid;
  logic               front_ready;
  cmd_t               front_cmd;
  logic               queue_valid;
  logic               queue_ready;
  cmd_t               queue_cmd;

  assign cfg_ready = 1'b1;

  // Color registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FG_COLOR: fg_color <= cfg_data;
        REG_BG_COLOR: bg_color <= cfg_data;
        default: begin
          fg_color <= fg_color;
        end
      endcase
    end
  end

  ctw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .char_code (char_code),
    .column    (column),
    .row       (row),
    .cell_index(cell_index),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  ctw_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_cmd   (front_cmd),
    .out_valid(queue_valid),
    .out_ready(queue_ready),
    .out_cmd  (queue_cmd)
  );

  ctw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .attr       ({bg_color, fg_color}),
    .cmd_valid  (queue_valid),
    .cmd_ready  (queue_ready),
    .cmd        (queue_cmd),
    .pop        (pop),
    .empty      (empty),
    .cursor_pos (cursor_pos),
    .cell_data  (cell_data),
    .text_length(text_length)
  );

endmodule

@@ sv/ctw_checker.sv @@
module ctw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [ctw_pkg::IDX_W-1:0]    cursor_pos,
  input logic [ctw_pkg::CELL_W-1:0]   cell_data,
  input logic [ctw_pkg::COUNT_W-1:0]  text_length,
  input logic                         cfg_ready
);
  import ctw_pkg::*;

  // Reset leaves no result waiting and the input open.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result or full flag left set after reset");

  // A result that is not taken stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(cursor_pos) && $stable(cell_data)
                          && $stable(text_length)))
    else $error("waiting result changed before it was taken");

  // The reported cursor always lies on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (cursor_pos < IDX_W'(CELL_COUNT)))
    else $error("cursor position off the screen");

  // Color writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind text_console_cell_writer_core ctw_checker u_checker (.*);
